// ----- rtl/pgm_stream_parser_macros.svh -----
// Assertion macros used by the parser's top-level RTL file.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef PGM_STREAM_PARSER_MACROS_SVH
`define PGM_STREAM_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pgm_sp_pkg.sv -----
package pgm_sp_pkg;

    localparam int DIM_BITS_DEFAULT = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_PIXEL  = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    localparam logic [1:0] ERR_MAGIC  = 2'd0;
    localparam logic [1:0] ERR_HEADER = 2'd1;
    localparam logic [1:0] ERR_DATA   = 2'd2;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_TWO   = 8'h32;
    localparam logic [7:0] CHAR_FIVE  = 8'h35;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    localparam logic [16:0] SAT_LIMIT = 17'h10000;

    typedef enum logic [3:0] {
        PH_MAG0    = 4'd0,
        PH_MAG1    = 4'd1,
        PH_FIELD   = 4'd2,
        PH_COMMENT = 4'd3,
        PH_RAW     = 4'd4,
        PH_ASCII   = 4'd5
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } pgm_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] max_gray;
        logic        raw_format;
        logic        wide_pixels;
        logic [15:0] pixel;
        logic [1:0]  error_code;
        logic        last;
    } pgm_res_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       eos;
        logic       digit;
        logic [3:0] digit_val;
        logic       blank;
        logic       hash;
        logic       newline;
        logic       is_p;
        logic       is_two;
        logic       is_five;
    } pgm_item_t;

    typedef struct packed {
        logic [1:0]  field_number;
        logic        blank_seen;
        logic        digit_seen;
        logic [16:0] acc;
        logic        header_bad;
        logic [15:0] img_w;
        logic [15:0] img_h;
        logic [15:0] img_max;
        logic        binary_mode;
        logic [15:0] col;
        logic [15:0] row;
        logic [7:0]  high_byte;
        logic        high_pending;
    } pgm_ctx_t;

    function automatic pgm_res_t err_result(input logic [1:0] code);
        pgm_res_t r;
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic pgm_res_t pixel_result(input logic raw, input logic wide,
                                              input logic [15:0] value, input logic last);
        pgm_res_t r;
        r = '0;
        r.kind = KIND_PIXEL;
        r.raw_format = raw;
        r.wide_pixels = wide;
        r.pixel = value;
        r.last = last;
        return r;
    endfunction

endpackage

// ----- rtl/pgm_sp_front.sv -----
module pgm_sp_front
    import pgm_sp_pkg::*;
(
    input  logic      byte_valid,
    output logic      byte_ready,
    input  pgm_in_t   byte_item,
    output logic      q_push,
    input  logic      q_ready,
    output pgm_item_t q_item
);

    logic [7:0] c;

    assign c = byte_item.data_byte;
    assign byte_ready = q_ready;
    assign q_push = byte_valid && q_ready;

    always_comb
    begin
        q_item.data_byte = c;
        q_item.eos       = byte_item.end_of_stream;
        q_item.digit     = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        q_item.digit_val = c[3:0];
        q_item.blank     = (c == CHAR_TAB) || (c == CHAR_LF) || (c == CHAR_CR)
                           || (c == CHAR_SPACE);
        q_item.hash      = (c == CHAR_HASH);
        q_item.newline   = (c == CHAR_LF);
        q_item.is_p      = (c == CHAR_P);
        q_item.is_two    = (c == CHAR_TWO);
        q_item.is_five   = (c == CHAR_FIVE);
    end

endmodule

// ----- rtl/pgm_sp_queue.sv -----
module pgm_sp_queue
    import pgm_sp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      push_ready,
    input  pgm_item_t push_item,
    output logic      pop_valid,
    input  logic      pop,
    output pgm_item_t pop_item
);

    localparam int PtrBits = $clog2(QUEUE_DEPTH);
    localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

    pgm_item_t            entry_reg [QUEUE_DEPTH];
    logic [PtrBits-1:0]   wr_ptr_reg;
    logic [PtrBits-1:0]   rd_ptr_reg;
    logic [CntBits-1:0]   count_reg;
    logic [CntBits-1:0]   count_next;

    assign push_ready = (count_reg != CntBits'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrBits'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrBits'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/pgm_sp_back.sv -----
module pgm_sp_back
    import pgm_sp_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    input  pgm_item_t q_item,
    output logic      q_pop,
    output logic      result_valid,
    input  logic      result_ready,
    output pgm_res_t  result_item
);

    localparam logic [16:0] DIM_LIMIT = (DIM_BITS >= 16) ? SAT_LIMIT : 17'(1 << DIM_BITS);

    phase_t   phase_reg, phase_next;
    pgm_ctx_t ctx_reg, ctx_next;
    pgm_res_t res_reg, res_next;
    logic     res_valid_reg, res_valid_next;
    pgm_res_t pend_reg, pend_next;
    logic     pend_valid_reg, pend_valid_next;

    logic        out_free;
    logic        take;
    logic [1:0]  count;
    pgm_res_t    r0, r1;
    logic [20:0] acc_x10;
    logic [16:0] acc_sat;
    logic        wide;
    logic [15:0] ascii_val;
    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic        col_wrap;
    logic        pix_last;
    logic [15:0] raw_val;

    assign out_free = !res_valid_reg || result_ready;
    assign take     = q_valid && out_free && !pend_valid_reg;
    assign q_pop    = take;

    assign acc_x10 = 21'({ctx_reg.acc, 3'b000}) + 21'({ctx_reg.acc, 1'b0})
                     + 21'(q_item.digit_val);
    assign acc_sat = (acc_x10 > 21'(SAT_LIMIT)) ? SAT_LIMIT : acc_x10[16:0];
    assign wide      = |ctx_reg.img_max[15:8];
    assign ascii_val = wide ? ctx_reg.acc[15:0] : {8'h00, ctx_reg.acc[7:0]};
    assign raw_val   = wide ? {ctx_reg.high_byte, q_item.data_byte}
                            : {8'h00, q_item.data_byte};
    assign col_inc  = {1'b0, ctx_reg.col} + 17'd1;
    assign row_inc  = {1'b0, ctx_reg.row} + 17'd1;
    assign col_wrap = (col_inc >= {1'b0, ctx_reg.img_w});
    assign pix_last = col_wrap && (row_inc >= {1'b0, ctx_reg.img_h});

    always_comb
    begin
        phase_next = phase_reg;
        ctx_next   = ctx_reg;
        count      = 2'd0;
        r0         = '0;
        r1         = '0;
        if (take)
        begin
            if (q_item.eos)
            begin
                unique case (phase_reg)
                    PH_MAG0:
                    begin
                        phase_next = PH_MAG0;
                        ctx_next   = '0;
                    end
                    PH_MAG1:
                    begin
                        r0 = err_result(ERR_MAGIC);
                        count = 2'd1;
                        phase_next = PH_MAG0;
                        ctx_next   = '0;
                    end
                    PH_FIELD, PH_COMMENT:
                    begin
                        r0 = err_result(ERR_HEADER);
                        count = 2'd1;
                        phase_next = PH_MAG0;
                        ctx_next   = '0;
                    end
                    PH_ASCII:
                    begin
                        if (ctx_reg.digit_seen)
                        begin
                            r0 = pixel_result(ctx_reg.binary_mode, wide, ascii_val, pix_last);
                            r1 = err_result(ERR_DATA);
                            count = pix_last ? 2'd1 : 2'd2;
                        end
                        else
                        begin
                            r0 = err_result(ERR_DATA);
                            count = 2'd1;
                        end
                        phase_next = PH_MAG0;
                        ctx_next   = '0;
                    end
                    default:
                    begin
                        r0 = err_result(ERR_DATA);
                        count = 2'd1;
                        phase_next = PH_MAG0;
                        ctx_next   = '0;
                    end
                endcase
            end
            else
            begin
                unique case (phase_reg)
                    PH_MAG0:
                    begin
                        ctx_next.header_bad = !q_item.is_p;
                        phase_next = PH_MAG1;
                    end
                    PH_MAG1:
                    begin
                        if (ctx_reg.header_bad || !(q_item.is_two || q_item.is_five))
                        begin
                            r0 = err_result(ERR_MAGIC);
                            count = 2'd1;
                            phase_next = PH_MAG0;
                            ctx_next   = '0;
                        end
                        else
                        begin
                            ctx_next.binary_mode  = q_item.is_five;
                            ctx_next.field_number = 2'd0;
                            ctx_next.blank_seen   = 1'b0;
                            ctx_next.digit_seen   = 1'b0;
                            ctx_next.acc          = '0;
                            phase_next = PH_FIELD;
                        end
                    end
                    PH_COMMENT:
                    begin
                        if (q_item.newline)
                        begin
                            phase_next = PH_FIELD;
                        end
                    end
                    PH_FIELD:
                    begin
                        if (!ctx_reg.digit_seen)
                        begin
                            if (q_item.blank)
                            begin
                                ctx_next.blank_seen = 1'b1;
                            end
                            else if (q_item.hash)
                            begin
                                ctx_next.blank_seen = 1'b1;
                                phase_next = PH_COMMENT;
                            end
                            else if (!q_item.digit || !ctx_reg.blank_seen)
                            begin
                                r0 = err_result(ERR_HEADER);
                                count = 2'd1;
                                phase_next = PH_MAG0;
                                ctx_next   = '0;
                            end
                            else
                            begin
                                ctx_next.digit_seen = 1'b1;
                                ctx_next.acc = 17'(q_item.digit_val);
                            end
                        end
                        else if (q_item.digit)
                        begin
                            ctx_next.acc = acc_sat;
                        end
                        else if (ctx_reg.field_number != 2'd2)
                        begin
                            if ((ctx_reg.acc >= DIM_LIMIT) || (!q_item.blank && !q_item.hash))
                            begin
                                r0 = err_result(ERR_HEADER);
                                count = 2'd1;
                                phase_next = PH_MAG0;
                                ctx_next   = '0;
                            end
                            else
                            begin
                                if (ctx_reg.field_number == 2'd0)
                                begin
                                    ctx_next.img_w = ctx_reg.acc[15:0];
                                end
                                else
                                begin
                                    ctx_next.img_h = ctx_reg.acc[15:0];
                                end
                                ctx_next.field_number = ctx_reg.field_number + 2'd1;
                                ctx_next.digit_seen = 1'b0;
                                ctx_next.blank_seen = 1'b1;
                                ctx_next.acc = '0;
                                if (q_item.hash)
                                begin
                                    phase_next = PH_COMMENT;
                                end
                            end
                        end
                        else if (!q_item.blank || (ctx_reg.acc == '0) || ctx_reg.acc[16])
                        begin
                            r0 = err_result(ERR_HEADER);
                            count = 2'd1;
                            phase_next = PH_MAG0;
                            ctx_next   = '0;
                        end
                        else
                        begin
                            r0 = '0;
                            r0.kind        = KIND_HEADER;
                            r0.width       = ctx_reg.img_w;
                            r0.height      = ctx_reg.img_h;
                            r0.max_gray    = ctx_reg.acc[15:0];
                            r0.raw_format  = ctx_reg.binary_mode;
                            r0.wide_pixels = |ctx_reg.acc[15:8];
                            r0.last        = (ctx_reg.img_w == '0) || (ctx_reg.img_h == '0);
                            count = 2'd1;
                            ctx_next.img_max      = ctx_reg.acc[15:0];
                            ctx_next.acc          = '0;
                            ctx_next.digit_seen   = 1'b0;
                            ctx_next.blank_seen   = 1'b0;
                            ctx_next.col          = '0;
                            ctx_next.row          = '0;
                            ctx_next.high_pending = 1'b0;
                            if (r0.last)
                            begin
                                phase_next = PH_MAG0;
                                ctx_next   = '0;
                            end
                            else
                            begin
                                phase_next = ctx_reg.binary_mode ? PH_RAW : PH_ASCII;
                            end
                        end
                    end
                    PH_RAW:
                    begin
                        if (wide && !ctx_reg.high_pending)
                        begin
                            ctx_next.high_byte    = q_item.data_byte;
                            ctx_next.high_pending = 1'b1;
                        end
                        else
                        begin
                            r0 = pixel_result(ctx_reg.binary_mode, wide, raw_val, pix_last);
                            count = 2'd1;
                            ctx_next.high_pending = 1'b0;
                            ctx_next.col = col_wrap ? '0 : col_inc[15:0];
                            ctx_next.row = col_wrap ? row_inc[15:0] : ctx_reg.row;
                            if (pix_last)
                            begin
                                phase_next = PH_MAG0;
                                ctx_next   = '0;
                            end
                        end
                    end
                    PH_ASCII:
                    begin
                        if (q_item.digit)
                        begin
                            ctx_next.digit_seen = 1'b1;
                            ctx_next.acc = {1'b0, acc_x10[15:0]};
                        end
                        else if (!ctx_reg.digit_seen)
                        begin
                            if (!q_item.blank)
                            begin
                                r0 = err_result(ERR_DATA);
                                count = 2'd1;
                                phase_next = PH_MAG0;
                                ctx_next   = '0;
                            end
                        end
                        else
                        begin
                            r0 = pixel_result(ctx_reg.binary_mode, wide, ascii_val, pix_last);
                            r1 = err_result(ERR_DATA);
                            ctx_next.digit_seen = 1'b0;
                            ctx_next.acc = '0;
                            ctx_next.col = col_wrap ? '0 : col_inc[15:0];
                            ctx_next.row = col_wrap ? row_inc[15:0] : ctx_reg.row;
                            if (pix_last)
                            begin
                                count = 2'd1;
                                phase_next = PH_MAG0;
                                ctx_next   = '0;
                            end
                            else if (q_item.blank)
                            begin
                                count = 2'd1;
                            end
                            else
                            begin
                                count = 2'd2;
                                phase_next = PH_MAG0;
                                ctx_next   = '0;
                            end
                        end
                    end
                    default:
                    begin
                        phase_next = PH_MAG0;
                        ctx_next   = '0;
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        res_next        = res_reg;
        res_valid_next  = res_valid_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        if (pend_valid_reg)
        begin
            if (out_free)
            begin
                res_next        = pend_reg;
                res_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
            end
        end
        else if (take)
        begin
            res_next        = r0;
            res_valid_next  = (count != 2'd0);
            pend_next       = r1;
            pend_valid_next = (count == 2'd2);
        end
        else if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAG0;
            ctx_reg        <= '0;
            res_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            ctx_reg        <= ctx_next;
            res_valid_reg  <= res_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        pend_reg <= pend_next;
    end

    assign result_valid = res_valid_reg;
    assign result_item  = res_reg;

endmodule

// ----- rtl/pgm_stream_parser.sv -----
// A byte transfer is written into the queue; the back end pops it and registers its result.
// Throughput: one byte per cycle while result_ready keeps the output free; a byte that yields
// two results holds the back end until both transfers leave the single output register.
// A two-entry queue separates byte classification from the parser state machine.
// Reset (rst_n, asynchronous, active low) empties the queue and returns the parser to the magic.
module pgm_stream_parser
    import pgm_sp_pkg::*;
#(
    parameter int DIM_BITS = DIM_BITS_DEFAULT
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     byte_valid,
    output logic     byte_ready,
    input  pgm_in_t  byte_item,
    output logic     result_valid,
    input  logic     result_ready,
    output pgm_res_t result_item
);

`include "pgm_stream_parser_macros.svh"

    logic      q_push;
    logic      q_ready;
    pgm_item_t q_in;
    logic      q_valid;
    logic      q_pop;
    pgm_item_t q_out;

    pgm_sp_front u_front (
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .q_push     (q_push),
        .q_ready    (q_ready),
        .q_item     (q_in)
    );

    pgm_sp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_ready (q_ready),
        .push_item  (q_in),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_item   (q_out)
    );

    pgm_sp_back #(
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_item       (q_out),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_item  (result_item)
    );

    `PSP_ASSERT_SAME(a_pop_needs_item, q_pop, q_valid, "pop from an empty queue")
    `PSP_ASSERT_SAME(a_error_is_last, result_valid && (result_item.kind == KIND_ERROR),
        result_item.last, "error result without last")
    `PSP_ASSERT_SAME(a_pixel_no_header, result_valid && (result_item.kind == KIND_PIXEL),
        (result_item.width == '0) && (result_item.height == '0)
        && (result_item.max_gray == '0) && (result_item.error_code == '0),
        "pixel result carries header or error fields")
    `PSP_ASSERT_NEXT(a_stall_holds, result_valid && !result_ready, result_valid,
        "result dropped while stalled")

endmodule
